FILE: src/cea_pkg.sv
// Package for the 6502 effective address resolver: memory geometry, mode codes,
// controller/datapath command and status types, page mapping table.
// No dependencies.
`default_nettype none

package cea_pkg;

	localparam int MEM_PAGES  = 256;
	localparam int PAGE_BYTES = 256;
	localparam int MEM_DEPTH  = MEM_PAGES * PAGE_BYTES;
	localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

	typedef enum logic [3:0] {
		MODE_WRITE = 4'd0,
		MODE_IMM   = 4'd1,
		MODE_ABS   = 4'd2,
		MODE_ZP    = 4'd3,
		MODE_ABSX  = 4'd4,
		MODE_ABSY  = 4'd5,
		MODE_ZPX   = 4'd6,
		MODE_ZPY   = 4'd7,
		MODE_IND   = 4'd8,
		MODE_INDX  = 4'd9,
		MODE_INDY  = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_WRITE,
		KIND_IMM,
		KIND_DIRECT,
		KIND_INDIRECT
	} kind_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_PTR_LO,
		RD_PTR_HI,
		RD_OPER
	} rd_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    clr;
		logic    wr;
		rd_sel_t rd_sel;
		logic    cap_ptr;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  clr_last;
		logic  out_free;
	} dp_stat_t;

	typedef logic [MEM_ADDR_W-1:0] page_base_t [256];

	// Base memory address of each 6502 page; pages past the memory alias lower ones.
	function automatic page_base_t build_page_base();
		page_base_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = MEM_ADDR_W'((i % MEM_PAGES) * PAGE_BYTES);
		end
		return t;
	endfunction

	localparam page_base_t PAGE_BASE = build_page_base();

	function automatic logic [MEM_ADDR_W-1:0] mem_addr(logic [15:0] a);
		return PAGE_BASE[a[15:8]] | MEM_ADDR_W'(a[7:0]);
	endfunction

endpackage

`default_nettype wire

FILE: src/cea_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module cea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/cea_ctrl.sv
// Controller for the effective address resolver: sequences clearing, writes,
// pointer fetches and operand reads. Depends on cea_pkg.
`default_nettype none

module cea_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire cea_pkg::dp_stat_t stat,
	output logic                   in_ready,
	output cea_pkg::dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_PTR_LO,
		ST_PTR_HI,
		ST_EA,
		ST_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '{load_in: 1'b0, clr: 1'b0, wr: 1'b0, rd_sel: cea_pkg::RD_NONE,
			cap_ptr: 1'b0, load_out: 1'b0};
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					unique case (stat.kind)
						cea_pkg::KIND_WRITE:    state_d = ST_WRITE;
						cea_pkg::KIND_IMM:      state_d = ST_RESULT;
						cea_pkg::KIND_DIRECT:   state_d = ST_EA;
						cea_pkg::KIND_INDIRECT: state_d = ST_PTR_LO;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PTR_LO: begin
				cmd.rd_sel = cea_pkg::RD_PTR_LO;
				state_d = ST_PTR_HI;
			end
			ST_PTR_HI: begin
				cmd.rd_sel = cea_pkg::RD_PTR_HI;
				cmd.cap_ptr = 1'b1;
				state_d = ST_EA;
			end
			ST_EA: begin
				cmd.rd_sel = cea_pkg::RD_OPER;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				cmd.load_out = stat.out_free;
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/cea_dp.sv
// Datapath for the effective address resolver: input registers, address
// arithmetic, memory port, result register. Depends on cea_pkg and cea_ram.
`default_nettype none

module cea_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [39:0]      s_tdata,
	input  wire logic [3:0]       s_tuser,
	input  wire cea_pkg::dp_cmd_t cmd,
	input  wire logic             m_tready,
	output cea_pkg::dp_stat_t     stat,
	output logic                  m_tvalid,
	output logic [23:0]           m_tdata,
	output logic                  m_tuser
);

	cea_pkg::mode_t mode_q;
	logic [7:0] lo_q, hi_q, x_q, y_q, wd_q;
	logic [7:0] ptr_lo_q;
	logic [15:0] ea_q;
	logic [cea_pkg::MEM_ADDR_W-1:0] clr_q;
	logic out_valid_q;
	logic [15:0] ea_out_q;
	logic [7:0] byte_out_q;
	logic imm_out_q;

	logic [7:0] ptr_page, ptr_off, ptr_off_next;
	logic [15:0] abs16, ptr16, ea;
	logic [7:0] zpx, zpy;
	logic ram_en, ram_we;
	logic [cea_pkg::MEM_ADDR_W-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;
	logic is_imm;
	cea_pkg::kind_t kind;

	always_comb begin
		unique case (cea_pkg::mode_t'(s_tuser))
			cea_pkg::MODE_WRITE: kind = cea_pkg::KIND_WRITE;
			cea_pkg::MODE_IMM:   kind = cea_pkg::KIND_IMM;
			cea_pkg::MODE_ABS, cea_pkg::MODE_ZP, cea_pkg::MODE_ABSX, cea_pkg::MODE_ABSY,
			cea_pkg::MODE_ZPX, cea_pkg::MODE_ZPY:
				kind = cea_pkg::KIND_DIRECT;
			cea_pkg::MODE_IND, cea_pkg::MODE_INDX, cea_pkg::MODE_INDY:
				kind = cea_pkg::KIND_INDIRECT;
			default: kind = cea_pkg::KIND_NONE;
		endcase
	end

	assign stat = '{kind: kind,
		clr_last: (clr_q == cea_pkg::MEM_ADDR_W'(cea_pkg::MEM_DEPTH - 1)),
		out_free: (!out_valid_q || m_tready)};

	assign zpx = lo_q + x_q;
	assign zpy = lo_q + y_q;
	assign ptr_page = (mode_q == cea_pkg::MODE_IND) ? hi_q : 8'h00;
	assign ptr_off = (mode_q == cea_pkg::MODE_INDX) ? zpx : lo_q;
	assign ptr_off_next = ptr_off + 8'd1;
	assign abs16 = {hi_q, lo_q};
	assign ptr16 = {ram_rdata, ptr_lo_q};
	assign is_imm = (mode_q == cea_pkg::MODE_IMM);

	always_comb begin
		unique case (mode_q)
			cea_pkg::MODE_ABS:  ea = abs16;
			cea_pkg::MODE_ZP:   ea = {8'h00, lo_q};
			cea_pkg::MODE_ABSX: ea = abs16 + {8'h00, x_q};
			cea_pkg::MODE_ABSY: ea = abs16 + {8'h00, y_q};
			cea_pkg::MODE_ZPX:  ea = {8'h00, zpx};
			cea_pkg::MODE_ZPY:  ea = {8'h00, zpy};
			cea_pkg::MODE_IND, cea_pkg::MODE_INDX: ea = ptr16;
			cea_pkg::MODE_INDY: ea = ptr16 + {8'h00, y_q};
			default:            ea = 16'h0000;
		endcase
	end

	always_comb begin
		ram_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = clr_q;
		ram_wdata = 8'h00;
		priority if (cmd.clr) begin
			ram_en = 1'b1;
			ram_we = 1'b1;
		end else if (cmd.wr) begin
			ram_en = 1'b1;
			ram_we = 1'b1;
			ram_addr = cea_pkg::mem_addr(abs16);
			ram_wdata = wd_q;
		end else begin
			unique case (cmd.rd_sel)
				cea_pkg::RD_PTR_LO: begin
					ram_en = 1'b1;
					ram_addr = cea_pkg::mem_addr({ptr_page, ptr_off});
				end
				cea_pkg::RD_PTR_HI: begin
					ram_en = 1'b1;
					ram_addr = cea_pkg::mem_addr({ptr_page, ptr_off_next});
				end
				cea_pkg::RD_OPER: begin
					ram_en = 1'b1;
					ram_addr = cea_pkg::mem_addr(ea);
				end
				default: begin
					ram_en = 1'b0;
				end
			endcase
		end
	end

	cea_ram #(
		.WIDTH(8),
		.DEPTH(cea_pkg::MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= cea_pkg::mode_t'(s_tuser);
			lo_q <= s_tdata[7:0];
			hi_q <= s_tdata[15:8];
			x_q <= s_tdata[23:16];
			y_q <= s_tdata[31:24];
			wd_q <= s_tdata[39:32];
		end
		if (cmd.cap_ptr) ptr_lo_q <= ram_rdata;
		if (cmd.rd_sel == cea_pkg::RD_OPER) ea_q <= ea;
		if (cmd.load_out) begin
			imm_out_q <= is_imm;
			ea_out_q <= is_imm ? 16'h0000 : ea_q;
			byte_out_q <= is_imm ? lo_q : ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr && !stat.clr_last) clr_q <= clr_q + 1'b1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {byte_out_q, ea_out_q};
	assign m_tuser = imm_out_q;

endmodule

`default_nettype wire

FILE: src/cpu_6502_effective_address.sv
// 6502 effective address resolver over a single-port byte memory.
// After reset the memory is swept to zero, one byte per cycle (MEM_DEPTH = 65536 bytes),
// with s_tready low. A new word is taken only once the last one is through its steps:
// a write stores one byte, direct modes read the operand, indirect modes read two pointer
// bytes, then the operand. A result is loaded into the output register once that is free.
// A finished result waits in the output register while the next word is taken.
`default_nettype none

module cpu_6502_effective_address (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // low_byte, high_byte, index_x, index_y, write_data
	input  wire logic [3:0]  s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // effective_address, operand_byte
	output logic             m_tuser   // is_immediate
);

	cea_pkg::dp_cmd_t  cmd;
	cea_pkg::dp_stat_t stat;

	cea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	cea_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.m_tready (m_tready),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !s_tready)
		else $error("word accepted during memory clear");

	a_imm_zero_address: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'h0000))
		else $error("immediate result with nonzero address");

	a_mem_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cmd.rd_sel == cea_pkg::RD_NONE && !cmd.wr && !cmd.clr))
		else $error("memory busy while accepting a word");

endmodule

`default_nettype wire

FILE: test/tb_cpu_6502_effective_address.sv
// Testbench for cpu_6502_effective_address: streams writes and addressing requests,
// predicts address and operand from a shadow copy of memory, checks every result word.
// Depends on cea_pkg and the cpu_6502_effective_address RTL.
`timescale 1ns / 1ps

module tb_cpu_6502_effective_address;

	localparam logic [3:0] MODE_UNUSED_FIRST = 4'd11;
	localparam logic [3:0] MODE_UNUSED_LAST  = 4'd15;
	localparam int RANDOM_WORDS = 1120;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [3:0] mode;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] wd;
		bit         drain;
	} word_t;

	typedef struct {
		logic [15:0] ea;
		logic [7:0]  operand;
		logic        imm;
	} operand_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // low_byte, high_byte, index_x, index_y, write_data
	logic [3:0]  s_tuser = '0;  // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // effective_address, operand_byte
	logic        m_tuser;       // is_immediate

	word_t    pending_words[$];
	operand_t expected_operands[$];
	bit [7:0] shadow_mem [cea_pkg::MEM_DEPTH];
	int       fails = 0;
	int       words_in = 0;
	int       cycles = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       hold_left = 0;
	bit       hold_done = 0;
	int       pattern_left = 0;
	logic [7:0] ready_mask = 8'hFF;
	int       counted;
	bit       mid_drain_done;

	cpu_6502_effective_address dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit [7:0] peek(bit [15:0] a);
		return shadow_mem[int'(a) % cea_pkg::MEM_DEPTH];
	endfunction

	function automatic bit [15:0] fetch_ptr(bit [7:0] page, bit [7:0] offs);
		bit [7:0] nxt;
		nxt = offs + 8'd1;
		return {peek({page, nxt}), peek({page, offs})};
	endfunction

	function automatic bit resolve_operand(input word_t w, output operand_t r);
		bit [15:0] abs16;
		bit [15:0] ea;
		abs16 = {w.hi, w.lo};
		r = '{ea: '0, operand: '0, imm: 1'b0};
		case (w.mode)
			cea_pkg::MODE_WRITE: begin
				shadow_mem[int'(abs16) % cea_pkg::MEM_DEPTH] = w.wd;
				return 1'b0;
			end
			cea_pkg::MODE_IMM: begin
				r.operand = w.lo;
				r.imm = 1'b1;
				return 1'b1;
			end
			cea_pkg::MODE_ABS:  ea = abs16;
			cea_pkg::MODE_ZP:   ea = {8'h00, w.lo};
			cea_pkg::MODE_ABSX: ea = abs16 + 16'(w.x);
			cea_pkg::MODE_ABSY: ea = abs16 + 16'(w.y);
			cea_pkg::MODE_ZPX:  ea = {8'h00, 8'(w.lo + w.x)};
			cea_pkg::MODE_ZPY:  ea = {8'h00, 8'(w.lo + w.y)};
			cea_pkg::MODE_IND:  ea = fetch_ptr(w.hi, w.lo);
			cea_pkg::MODE_INDX: ea = fetch_ptr(8'h00, 8'(w.lo + w.x));
			cea_pkg::MODE_INDY: ea = fetch_ptr(8'h00, w.lo) + 16'(w.y);
			default: return 1'b0;
		endcase
		r.ea = ea;
		r.operand = peek(ea);
		return 1'b1;
	endfunction

	function automatic void push_word(logic [3:0] mode, logic [7:0] lo, logic [7:0] hi,
			logic [7:0] x, logic [7:0] y, logic [7:0] wd);
		pending_words.push_back('{mode: mode, lo: lo, hi: hi, x: x, y: y, wd: wd, drain: 1'b0});
	endfunction

	function automatic void push_drain();
		pending_words.push_back('{mode: '0, lo: '0, hi: '0, x: '0, y: '0, wd: '0, drain: 1'b1});
	endfunction

	function automatic logic [7:0] pick_page();
		logic [7:0] hot [3] = '{8'h01, 8'h12, 8'h80};
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2, 3: return hot[$urandom_range(0, 2)];
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_offset();
		logic [7:0] hot [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		if ($urandom_range(0, 1) == 0)
			return hot[$urandom_range(0, 5)];
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_data();
		if ($urandom_range(0, 1) == 0)
			return pick_page();
		return 8'($urandom);
	endfunction

	// Write a pointer and its target byte, then dereference it.
	function automatic int push_pointer_chain();
		logic [3:0] mode;
		logic [7:0] lo, hi, x, y, pg, offs, tlo, thi;
		logic [15:0] target;
		mode = 4'($urandom_range(cea_pkg::MODE_IND, cea_pkg::MODE_INDY));
		lo = pick_offset();
		hi = pick_page();
		x = 8'($urandom);
		y = 8'($urandom);
		tlo = 8'($urandom);
		thi = pick_page();
		pg = (mode == cea_pkg::MODE_IND) ? hi : 8'h00;
		offs = (mode == cea_pkg::MODE_INDX) ? 8'(lo + x) : lo;
		target = {thi, tlo} + ((mode == cea_pkg::MODE_INDY) ? 16'(y) : 16'h0000);
		push_word(cea_pkg::MODE_WRITE, offs, pg, 8'($urandom), 8'($urandom), tlo);
		push_word(cea_pkg::MODE_WRITE, 8'(offs + 8'd1), pg, 8'($urandom), 8'($urandom), thi);
		push_word(cea_pkg::MODE_WRITE, target[7:0], target[15:8], 8'($urandom),
			8'($urandom), 8'($urandom));
		push_word(mode, lo, hi, x, y, 8'($urandom));
		return 4;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_words.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_words[0].drain) begin
				s_tvalid <= 1'b0;
				if (!s_tvalid && expected_operands.size() == 0)
					void'(pending_words.pop_front());
			end else begin
				word_t w;
				w = pending_words.pop_front();
				s_tdata <= {w.wd, w.y, w.x, w.hi, w.lo};
				s_tuser <= w.mode;
				s_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 64);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			pattern_left <= 0;
			ready_mask <= 8'hFF;
		end else begin
			if (!hold_done && words_in >= 250) begin
				hold_done <= 1'b1;
				hold_left <= 500;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
			if (pattern_left == 0) begin
				pattern_left <= 32;
				ready_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
			end else begin
				pattern_left <= pattern_left - 1;
				ready_mask <= {ready_mask[0], ready_mask[7:1]};
			end
			m_tready <= (hold_left == 0) && ready_mask[0];
		end
	end

	always @(posedge clk) begin : track_input
		word_t w;
		operand_t r;
		if (arst_n && s_tvalid && s_tready) begin
			w.mode = s_tuser;
			w.lo = s_tdata[7:0];
			w.hi = s_tdata[15:8];
			w.x = s_tdata[23:16];
			w.y = s_tdata[31:24];
			w.wd = s_tdata[39:32];
			w.drain = 1'b0;
			words_in <= words_in + 1;
			if (resolve_operand(w, r))
				expected_operands.push_back(r);
		end
	end

	always @(posedge clk) begin : check_output
		operand_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_operands.size() == 0) begin
				$error("unexpected result word: effective_address %h", m_tdata[15:0]);
				fails++;
			end else begin
				want = expected_operands.pop_front();
				if (m_tdata[15:0] !== want.ea) begin
					$error("effective_address: expected %h, got %h", want.ea, m_tdata[15:0]);
					fails++;
				end
				if (m_tdata[23:16] !== want.operand) begin
					$error("operand_byte: expected %h, got %h", want.operand, m_tdata[23:16]);
					fails++;
				end
				if (m_tuser !== want.imm) begin
					$error("is_immediate: expected %b, got %b", want.imm, m_tuser);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL cpu_6502_effective_address");
			$finish;
		end
	end

	initial begin
		// pointer at $00FF wraps to $0000 for its high byte
		push_word(cea_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h34);
		push_word(cea_pkg::MODE_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12);
		push_word(cea_pkg::MODE_WRITE, 8'h34, 8'h12, 8'h00, 8'h00, 8'hC3);
		push_word(cea_pkg::MODE_WRITE, 8'hFF, 8'h12, 8'hFF, 8'hFF, 8'h78);
		push_word(cea_pkg::MODE_WRITE, 8'h00, 8'h12, 8'h00, 8'h00, 8'h56);
		push_word(cea_pkg::MODE_WRITE, 8'h78, 8'h56, 8'h00, 8'h00, 8'h9E);
		push_word(cea_pkg::MODE_WRITE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF);
		push_word(cea_pkg::MODE_IMM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_IMM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_word(cea_pkg::MODE_ABS, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ABS, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ABS, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00);
		push_word(cea_pkg::MODE_ZP, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ABSX, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ABSX, 8'hFF, 8'h12, 8'h01, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ABSY, 8'h34, 8'h12, 8'h00, 8'hFF, 8'h00);
		push_word(cea_pkg::MODE_ZPX, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_ZPY, 8'h80, 8'h00, 8'h00, 8'h80, 8'h00);
		push_word(cea_pkg::MODE_IND, 8'hFF, 8'h12, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_INDX, 8'hFE, 8'h00, 8'h01, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_INDX, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_INDY, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
		push_word(cea_pkg::MODE_INDY, 8'hFF, 8'h00, 8'h00, 8'hCC, 8'h00);
		push_word(MODE_UNUSED_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_word(MODE_UNUSED_FIRST, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
		push_drain();

		counted = 0;
		mid_drain_done = 0;
		while (counted < RANDOM_WORDS) begin
			int r;
			r = $urandom_range(0, 99);
			if (!mid_drain_done && counted >= RANDOM_WORDS / 2) begin
				push_drain();
				mid_drain_done = 1;
			end
			if (r < 12)
				counted += push_pointer_chain();
			else if (r < 40) begin
				push_word(cea_pkg::MODE_WRITE, pick_offset(), pick_page(), 8'($urandom),
					8'($urandom), pick_data());
				counted++;
			end else if (r < 45)
				push_word(4'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			else begin
				push_word(4'($urandom_range(cea_pkg::MODE_IMM, cea_pkg::MODE_INDY)),
					pick_offset(), pick_page(), 8'($urandom), 8'($urandom), 8'($urandom));
				counted++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_operands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("PASS cpu_6502_effective_address");
		else
			$display("FAIL cpu_6502_effective_address");
		$finish;
	end

endmodule

FILE: filelist.f
src/cea_pkg.sv
src/cea_ram.sv
src/cea_ctrl.sv
src/cea_dp.sv
src/cpu_6502_effective_address.sv
test/tb_cpu_6502_effective_address.sv
